[hw/rtl/pic_pkg.sv]
// Package for pulse_interval_capture: buffer sizing, op and register codes,
// and the structs passed between the controller, the RAM and the top level.
// No dependencies.
package pic_pkg;

    localparam int BUFFER_DEPTH = 512;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int TIME_W       = 32;
    localparam int IVAL_W       = 16;
    localparam int PLEN_W       = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [1:0] OP_EDGE    = 2'd0;
    localparam logic [1:0] OP_POLL    = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PKT_LEN  = 2'd2;

    localparam logic [IVAL_W-1:0] MIN_INTERVAL_RST = 16'd100;
    localparam logic [IVAL_W-1:0] MAX_INTERVAL_RST = 16'd10000;
    localparam logic [PLEN_W-1:0] MIN_PKT_LEN_RST  = 13'd20;

    typedef struct packed {
        logic [IVAL_W-1:0] min_interval;
        logic [IVAL_W-1:0] max_interval;
        logic [PLEN_W-1:0] min_packet_length;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [IVAL_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic              ready_res;
        logic [CNT_W-1:0]  stored_count;
        logic              capturing;
        logic [IVAL_W-1:0] read_value;
        logic              read_valid;
    } res_t;

endpackage

[hw/rtl/pulse_interval_capture.sv]
// Top level of the pulse interval capture block: configuration registers,
// controller and interval RAM. Depends on pic_pkg, pic_ctrl and pic_ram.
//
//   channel   handshake               payload
//   command   start & !busy           op, now_us, read_index
//   result    done (one cycle)        ready_res, stored_count, capturing,
//                                     read_value, read_valid
//   config    cfg_valid & cfg_ready   cfg_index, cfg_data
//
// For every command the RAM read is launched at accept, the update and
// write-back happen in the following cycle, and done is high the cycle
// after that. A new command can be accepted in the done cycle, but not
// while busy is high for the previous one. Reset clears all capture state;
// the RAM needs no clearing pass. The receiver cannot stall results.
module pulse_interval_capture (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        op,
    input  logic [pic_pkg::TIME_W-1:0]        now_us,
    input  logic [pic_pkg::ADDR_W-1:0]        read_index,
    output logic                              done,
    output logic                              ready_res,
    output logic [pic_pkg::CNT_W-1:0]         stored_count,
    output logic                              capturing,
    output logic [pic_pkg::IVAL_W-1:0]        read_value,
    output logic                              read_valid,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pic_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pic_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pic_pkg::*;

    cfg_t              cfg_reg;
    ram_wr_t           wr;
    res_t              res;
    logic [IVAL_W-1:0] rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_interval      <= MIN_INTERVAL_RST;
            cfg_reg.max_interval      <= MAX_INTERVAL_RST;
            cfg_reg.min_packet_length <= MIN_PKT_LEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIN_INTERVAL: cfg_reg.min_interval      <= cfg_data[IVAL_W-1:0];
                REG_MAX_INTERVAL: cfg_reg.max_interval      <= cfg_data[IVAL_W-1:0];
                REG_MIN_PKT_LEN:  cfg_reg.min_packet_length <= cfg_data[PLEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    pic_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (op),
        .now_us     (now_us),
        .read_index (read_index),
        .cfg        (cfg_reg),
        .rd_data    (rd_data),
        .busy       (busy),
        .wr         (wr),
        .res        (res),
        .done       (done)
    );

    pic_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (start && !busy),
        .rd_addr (read_index),
        .rd_data (rd_data)
    );

    assign ready_res    = res.ready_res;
    assign stored_count = res.stored_count;
    assign capturing    = res.capturing;
    assign read_value   = res.read_value;
    assign read_valid   = res.read_valid;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not enter execute");

    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("execute cycle not followed by done");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a preceding execute cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (stored_count <= CNT_W'(BUFFER_DEPTH)))
        else $error("stored count beyond buffer depth");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && read_valid) |-> (stored_count != '0))
        else $error("valid read from an empty buffer");

endmodule

[hw/rtl/pic_ram.sv]
// Interval buffer RAM: one write port, one read port with registered data.
// Depends on pic_pkg.
module pic_ram (
    input  logic                          clk,
    input  pic_pkg::ram_wr_t              wr,
    input  logic                          rd_en,
    input  logic [pic_pkg::ADDR_W-1:0]    rd_addr,
    output logic [pic_pkg::IVAL_W-1:0]    rd_data
);
    import pic_pkg::*;

    logic [IVAL_W-1:0] mem [BUFFER_DEPTH];
    logic [IVAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/pic_ctrl.sv]
// Capture controller: edge/poll/read/release sequencing, capture state
// and buffer write-back. Depends on pic_pkg.
module pic_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    op,
    input  logic [pic_pkg::TIME_W-1:0]    now_us,
    input  logic [pic_pkg::ADDR_W-1:0]    read_index,
    input  pic_pkg::cfg_t                 cfg,
    input  logic [pic_pkg::IVAL_W-1:0]    rd_data,
    output logic                          busy,
    output pic_pkg::ram_wr_t              wr,
    output pic_pkg::res_t                 res,
    output logic                          done
);
    import pic_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic              state_reg, state_next;
    logic [1:0]        op_reg;
    logic [TIME_W-1:0] now_reg;
    logic [ADDR_W-1:0] idx_reg;

    logic [TIME_W-1:0] last_edge_reg, last_edge_next;
    logic              active_reg, active_next;
    logic [CNT_W-1:0]  wpos_reg, wpos_next;
    logic              ready_reg, ready_next;

    res_t              res_reg, res_next;
    logic              done_reg;

    logic [TIME_W-1:0] gap;
    logic              gap_low, gap_high, blocked;
    logic              rvalid;

    assign busy = (state_reg == ST_EXEC);

    assign gap      = now_reg - last_edge_reg;
    assign gap_low  = gap < {{(TIME_W-IVAL_W){1'b0}}, cfg.min_interval};
    assign gap_high = gap > {{(TIME_W-IVAL_W){1'b0}}, cfg.max_interval};
    assign blocked  = ready_reg || (wpos_reg >= CNT_W'(BUFFER_DEPTH));
    assign rvalid   = {{(CNT_W-ADDR_W){1'b0}}, idx_reg} < wpos_reg;

    always_comb
    begin
        state_next     = state_reg;
        last_edge_next = last_edge_reg;
        active_next    = active_reg;
        wpos_next      = wpos_reg;
        ready_next     = ready_reg;
        wr.en          = 1'b0;
        wr.addr        = wpos_reg[ADDR_W-1:0];
        wr.data        = gap[IVAL_W-1:0];
        res_next       = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                unique case (op_reg)
                    OP_EDGE:
                    begin
                        if (!blocked)
                        begin
                            if (active_reg && (gap_low || gap_high))
                            begin
                                active_next = 1'b0;
                            end
                            else
                            begin
                                if (active_reg)
                                begin
                                    wr.en     = 1'b1;
                                    wpos_next = wpos_reg + CNT_W'(1);
                                end
                                last_edge_next = now_reg;
                                active_next    = 1'b1;
                            end
                        end
                    end
                    OP_POLL:
                    begin
                        if (active_reg && gap_high)
                        begin
                            active_next = 1'b0;
                            if (({{(PLEN_W-CNT_W){1'b0}}, wpos_reg} + PLEN_W'(1))
                                > cfg.min_packet_length)
                            begin
                                ready_next = 1'b1;
                            end
                            else
                            begin
                                wpos_next  = '0;
                                ready_next = 1'b0;
                            end
                        end
                    end
                    OP_READ:
                    begin
                    end
                    OP_RELEASE:
                    begin
                        wpos_next  = '0;
                        ready_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
                res_next.ready_res    = ready_next;
                res_next.stored_count = wpos_next;
                res_next.capturing    = active_next;
                res_next.read_valid   = (op_reg == OP_READ) && rvalid;
                res_next.read_value   = ((op_reg == OP_READ) && rvalid) ? rd_data : '0;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_edge_reg <= '0;
            active_reg    <= 1'b0;
            wpos_reg      <= '0;
            ready_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_edge_reg <= last_edge_next;
            active_reg    <= active_next;
            wpos_reg      <= wpos_next;
            ready_reg     <= ready_next;
            done_reg      <= (state_reg == ST_EXEC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg  <= op;
            now_reg <= now_us;
            idx_reg <= read_index;
        end
        res_reg <= res_next;
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule
